FILE: sv/brhc_pkg.sv
// types, codes and constants for the request header checker
package brhc_pkg;

    localparam logic [31:0] REQ_MAGIC      = 32'h2560_9513;
    localparam logic [31:0] MAX_DATA_RESET = 32'd67108864;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPORT_FLAGS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRUCTURED_ON = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ALLOC_ON = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPORT_SIZE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATA      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTTING_DOWN = 3'd5;

    localparam logic [15:0] OP_READ   = 16'd0;
    localparam logic [15:0] OP_WRITE  = 16'd1;
    localparam logic [15:0] OP_DISC   = 16'd2;
    localparam logic [15:0] OP_FLUSH  = 16'd3;
    localparam logic [15:0] OP_TRIM   = 16'd4;
    localparam logic [15:0] OP_CACHE  = 16'd5;
    localparam logic [15:0] OP_ZEROES = 16'd6;
    localparam logic [15:0] OP_STATUS = 16'd7;

    // transmission flag bit positions
    localparam int EF_READ_ONLY = 1;
    localparam int EF_FLUSH     = 2;
    localparam int EF_FUA       = 3;
    localparam int EF_TRIM      = 5;
    localparam int EF_ZEROES    = 6;
    localparam int EF_CACHE     = 10;

    // command flag bit positions
    localparam int CF_FUA       = 0;
    localparam int CF_NO_HOLE   = 1;
    localparam int CF_DF        = 2;
    localparam int CF_REQ_ONE   = 3;
    localparam int CF_FAST_ZERO = 4;
    localparam int CF_KNOWN_W   = 5;

    // backend flag bit positions
    localparam int BF_FUA       = 0;
    localparam int BF_MAY_TRIM  = 1;
    localparam int BF_FAST_ZERO = 2;
    localparam int BF_REQ_ONE   = 3;

    localparam logic [1:0] VERDICT_FORWARD = 2'd0;
    localparam logic [1:0] VERDICT_ERROR   = 2'd1;
    localparam logic [1:0] VERDICT_DISC    = 2'd2;
    localparam logic [1:0] VERDICT_DEAD    = 2'd3;

    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_PERM  = 3'd1;
    localparam logic [2:0] ERR_NOSPC = 3'd2;
    localparam logic [2:0] ERR_NOMEM = 3'd3;
    localparam logic [2:0] ERR_INVAL = 3'd4;
    localparam logic [2:0] ERR_SHUT  = 3'd5;

    localparam logic [1:0] KIND_SIMPLE = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    typedef struct packed {
        logic [15:0] export_flags;
        logic        structured_on;
        logic        base_alloc_on;
        logic [62:0] export_size;
        logic [31:0] max_data_bytes;
        logic        shutting_down;
    } cfg_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] op;
        logic [15:0] cmd_flags;
        logic [63:0] offset;
        logic [31:0] length;
    } hdr_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [2:0] error_class;
        logic [1:0] reply_kind;
        logic       skip_payload;
        logic [3:0] backend_flags;
    } res_t;

endpackage

FILE: sv/block_request_header_checker_top.sv
// top level of the request header checker
//
//  channel   | handshake        | payload
//  ----------+------------------+--------------------------------------------------
//  request   | start / busy     | magic, op, cmd_flags, offset, length
//  result    | done (strobe)    | verdict, error_class, reply_kind, skip_payload,
//            |                  | backend_flags
//  config    | cfg_we           | cfg_index, cfg_data
//
// one item per cycle; a taken item reaches the result outputs through the
// header register, then the result register, around one pass of check logic
// busy is always low: both stages advance every cycle
// the receiver cannot stall, so done is a one-cycle strobe
// reset clears the valid flags and loads the register defaults
module block_request_header_checker_top
    import brhc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [31:0]          magic,
    input  logic [15:0]          op,
    input  logic [15:0]          cmd_flags,
    input  logic [63:0]          offset,
    input  logic [31:0]          length,
    output logic                 done,
    output logic [1:0]           verdict,
    output logic [2:0]           error_class,
    output logic [1:0]           reply_kind,
    output logic                 skip_payload,
    output logic [3:0]           backend_flags,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [62:0]          cfg_data
);

    cfg_t cfg;
    hdr_t hdr_reg;
    logic hdr_vld_reg;
    res_t res_comb;
    res_t res_reg;
    logic res_vld_reg;

    brhc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    brhc_check u_check (
        .cfg (cfg),
        .hdr (hdr_reg),
        .res (res_comb)
    );

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            hdr_vld_reg <= start && !busy;
            res_vld_reg <= hdr_vld_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            hdr_reg <= '{magic: magic, op: op, cmd_flags: cmd_flags,
                         offset: offset, length: length};
        if (hdr_vld_reg)
            res_reg <= res_comb;
    end

    assign done          = res_vld_reg;
    assign verdict       = res_reg.verdict;
    assign error_class   = res_reg.error_class;
    assign reply_kind    = res_reg.reply_kind;
    assign skip_payload  = res_reg.skip_payload;
    assign backend_flags = res_reg.backend_flags;

endmodule

FILE: sv/brhc_cfg.sv
// configuration register bank
module brhc_cfg
    import brhc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [62:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXPORT_FLAGS:  cfg_next.export_flags   = cfg_data[15:0];
                CFG_STRUCTURED_ON: cfg_next.structured_on  = cfg_data[0];
                CFG_BASE_ALLOC_ON: cfg_next.base_alloc_on  = cfg_data[0];
                CFG_EXPORT_SIZE:   cfg_next.export_size    = cfg_data;
                CFG_MAX_DATA:      cfg_next.max_data_bytes = cfg_data[31:0];
                CFG_SHUTTING_DOWN: cfg_next.shutting_down  = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.export_flags   <= '0;
            cfg_reg.structured_on  <= 1'b0;
            cfg_reg.base_alloc_on  <= 1'b0;
            cfg_reg.export_size    <= '0;
            cfg_reg.max_data_bytes <= MAX_DATA_RESET;
            cfg_reg.shutting_down  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/brhc_check.sv
// header checks and result encoding for one item
module brhc_check
    import brhc_pkg::*;
(
    input  cfg_t cfg,
    input  hdr_t hdr,
    output res_t res
);

    logic        is_read;
    logic        is_write;
    logic        is_flush;
    logic        is_trim;
    logic        is_cache;
    logic        is_zeroes;
    logic        is_status;
    logic        data_op;
    logic [64:0] end_pos;
    logic        in_range;
    logic        len_zero;
    logic [32:0] twice_max;
    logic        structured;
    logic [15:0] fl;
    logic [15:0] ef;
    logic [2:0]  err;
    logic [2:0]  err_final;

    assign fl = hdr.cmd_flags;
    assign ef = cfg.export_flags;

    assign is_read   = (hdr.op == OP_READ);
    assign is_write  = (hdr.op == OP_WRITE);
    assign is_flush  = (hdr.op == OP_FLUSH);
    assign is_trim   = (hdr.op == OP_TRIM);
    assign is_cache  = (hdr.op == OP_CACHE);
    assign is_zeroes = (hdr.op == OP_ZEROES);
    assign is_status = (hdr.op == OP_STATUS);
    assign data_op   = hdr.op inside {OP_READ, OP_WRITE, OP_TRIM, OP_CACHE,
                                      OP_ZEROES, OP_STATUS};

    // 65-bit sum so the range test cannot wrap
    assign end_pos   = {1'b0, hdr.offset} + {33'd0, hdr.length};
    assign len_zero  = (hdr.length == '0);
    assign in_range  = !len_zero && (end_pos <= {2'b00, cfg.export_size});
    assign twice_max = {cfg.max_data_bytes, 1'b0};
    assign structured = cfg.structured_on && (is_read || is_status);

    always_comb
    begin
        if (ef[EF_READ_ONLY] && (is_write || is_trim || is_zeroes))
            err = ERR_PERM;
        else if (data_op && !in_range)
            err = (is_write || is_zeroes) ? ERR_NOSPC : ERR_INVAL;
        else if (is_flush && ((hdr.offset != '0) || !len_zero))
            err = ERR_INVAL;
        else if (!data_op && !is_flush)
            err = ERR_INVAL;
        else if (fl[15:CF_KNOWN_W] != '0)
            err = ERR_INVAL;
        else if (fl[CF_NO_HOLE] && !is_zeroes)
            err = ERR_INVAL;
        else if (fl[CF_FAST_ZERO] && !is_zeroes)
            err = ERR_INVAL;
        else if (fl[CF_DF] && (!is_read || !cfg.structured_on))
            err = ERR_INVAL;
        else if (fl[CF_REQ_ONE] && !is_status)
            err = ERR_INVAL;
        else if (fl[CF_FUA] && !ef[EF_FUA])
            err = ERR_INVAL;
        else if ((is_write || is_read) && ({1'b0, hdr.length} > {1'b0, cfg.max_data_bytes}))
            err = ERR_NOMEM;
        else if (is_flush && !ef[EF_FLUSH])
            err = ERR_INVAL;
        else if (is_trim && !ef[EF_TRIM])
            err = ERR_INVAL;
        else if (is_zeroes && !ef[EF_ZEROES])
            err = ERR_INVAL;
        else if (is_cache && !ef[EF_CACHE])
            err = ERR_INVAL;
        else if (is_status && (!cfg.structured_on || !cfg.base_alloc_on))
            err = ERR_INVAL;
        else
            err = ERR_NONE;
    end

    always_comb
    begin
        res       = '0;
        err_final = err;
        if (hdr.magic != REQ_MAGIC)
        begin
            res.verdict = VERDICT_DEAD;
        end
        else if (hdr.op == OP_DISC)
        begin
            res.verdict = VERDICT_DISC;
        end
        else if ((err != ERR_NONE) && is_write && ({1'b0, hdr.length} > twice_max))
        begin
            // payload too large to drain
            res.verdict = VERDICT_DEAD;
        end
        else
        begin
            if ((err == ERR_NONE) && cfg.shutting_down)
                err_final = ERR_SHUT;
            if (err_final != ERR_NONE)
            begin
                res.verdict      = VERDICT_ERROR;
                res.error_class  = err_final;
                res.reply_kind   = structured ? KIND_ERROR : KIND_SIMPLE;
                res.skip_payload = is_write;
            end
            else
            begin
                res.verdict = VERDICT_FORWARD;
                if (structured)
                    res.reply_kind = is_read ? KIND_READ : KIND_STATUS;
                if (is_write || is_trim)
                begin
                    res.backend_flags[BF_FUA] = fl[CF_FUA];
                end
                else if (is_zeroes)
                begin
                    res.backend_flags[BF_MAY_TRIM]  = !fl[CF_NO_HOLE];
                    res.backend_flags[BF_FUA]       = fl[CF_FUA];
                    res.backend_flags[BF_FAST_ZERO] = fl[CF_FAST_ZERO];
                end
                else if (is_status)
                begin
                    res.backend_flags[BF_REQ_ONE] = fl[CF_REQ_ONE];
                end
            end
        end
    end

endmodule

FILE: sv/brhc_sva.sv
// port-level checks for the request header checker
module brhc_sva
    import brhc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [1:0]           verdict,
    input logic [2:0]           error_class,
    input logic [1:0]           reply_kind,
    input logic                 skip_payload,
    input logic [3:0]           backend_flags
);

    // one result for every item, after the header and result registers
    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(start && !busy && rst_n, 2) && $past(rst_n)) |-> done)
        else $error("item without result");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without item");

    // closing verdicts carry nothing else
    a_close_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (verdict == VERDICT_DEAD || verdict == VERDICT_DISC)) |->
        (error_class == ERR_NONE && reply_kind == KIND_SIMPLE &&
         !skip_payload && backend_flags == 4'd0))
        else $error("closing verdict with extra fields");

    a_forward_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && verdict == VERDICT_FORWARD) |->
        (error_class == ERR_NONE && !skip_payload))
        else $error("forwarded item with error fields");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && verdict == VERDICT_ERROR) |->
        (error_class != ERR_NONE && backend_flags == 4'd0 &&
         reply_kind != KIND_READ && reply_kind != KIND_STATUS))
        else $error("error reply with bad fields");

endmodule

bind block_request_header_checker_top brhc_sva u_brhc_sva (.*);
